>>> sv/tsp_pkg.sv
// tsp_pkg: shared types, field widths and codes of the trapezoid speed profile unit
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package tsp_pkg;

	localparam int SPEED_FRAC_BITS_DEF = 8;

	// item and result field widths
	localparam int CMD_W       = 1;
	localparam int KIND_W      = 2;
	localparam int LEN_W       = 16;
	localparam int TGT_W       = 12;
	localparam int STEP_W      = 32;
	localparam int VEL_W       = 23;
	localparam int PHASE_W     = 3;

	// configuration register widths and formats
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int FLOOR_W     = 12;
	localparam int ACC_CFG_W   = 16;
	localparam int ACC_CFG_FRAC = 8;
	localparam int MPS_W       = 32;
	localparam int MPS_FRAC    = 24;
	localparam int VSC_W       = 32;
	localparam int VSC_FRAC    = 16;

	// shared multiplier operand width
	localparam int MUL_W       = 32;

	// braking distance factor 2 * 1000
	localparam int BRAKE_K_W   = 11;
	localparam logic [BRAKE_K_W-1:0] BRAKE_K = 11'd2000;

	localparam logic [VEL_W-1:0]  VEL_SAT  = 23'h7F_FFFF;
	localparam logic [STEP_W-1:0] GOAL_SAT = 32'h7FFF_FFFF;

	localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_START = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CONST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DECEL = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLOOR_SPEED = 2'd0,
		CFG_ACCEL       = 2'd1,
		CFG_MM_PER_STEP = 2'd2,
		CFG_VEL_SCALE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE   = 3'd0,
		PH_RAMP   = 3'd1,
		PH_CRUISE = 3'd2,
		PH_HOLD   = 3'd3,
		PH_BRAKE  = 3'd4
	} phase_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_GOAL_DIV,
		ST_GOAL_WAIT,
		ST_STEP,
		ST_VEL_MUL,
		ST_VEL_SAT,
		ST_GOAL_CMP,
		ST_TRAV_MUL,
		ST_REM,
		ST_SQ_MUL,
		ST_FL_MUL,
		ST_NUM,
		ST_BRAKE_DIV,
		ST_BRAKE_WAIT,
		ST_BRAKE_CMP,
		ST_RESULT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIV_GOAL,
		OP_START_SET,
		OP_STEP,
		OP_MUL_VEL,
		OP_VEL_SAT,
		OP_GOAL_CMP,
		OP_MUL_TRAV,
		OP_REM,
		OP_MUL_SQ,
		OP_MUL_FL,
		OP_NUM,
		OP_DIV_BRAKE,
		OP_BRAKE_CMP,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   capture;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             kind_ok;
		phase_t           phase;
		logic             div_done;
	} dp_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [KIND_W-1:0] move_kind;
		logic [LEN_W-1:0]  move_length;
		logic [TGT_W-1:0]  target_speed;
		logic [STEP_W-1:0] step_count;
	} item_t;

	typedef struct packed {
		logic               velocity_write;
		logic [VEL_W-1:0]   velocity_cmd;
		logic               clear_count;
		logic               done_res;
		logic [PHASE_W-1:0] phase;
	} res_t;

endpackage

>>> sv/tsp_if.sv
// tsp_req_if / tsp_rsp_if: valid/ready channels for move items and profile results
// depends on tsp_pkg for the field widths
interface tsp_req_if
	import tsp_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [KIND_W-1:0]        move_kind;
	logic [LEN_W-1:0]         move_length;
	logic [TGT_W-1:0]         target_speed;
	logic signed [STEP_W-1:0] step_count;

	modport source (
		output valid, cmd, move_kind, move_length, target_speed, step_count,
		input  ready
	);
	modport sink (
		input  valid, cmd, move_kind, move_length, target_speed, step_count,
		output ready
	);
endinterface

interface tsp_rsp_if
	import tsp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               velocity_write;
	logic [VEL_W-1:0]   velocity_cmd;
	logic               clear_count;
	logic               done_res;
	logic [PHASE_W-1:0] phase;

	modport source (
		output valid, velocity_write, velocity_cmd, clear_count, done_res, phase,
		input  ready
	);
	modport sink (
		input  valid, velocity_write, velocity_cmd, clear_count, done_res, phase,
		output ready
	);
endinterface

>>> sv/trapezoid_speed_profile_unit.sv
// trapezoid_speed_profile_unit: top level of the trapezoidal speed profile
// depends on tsp_pkg, tsp_if, tsp_div, tsp_ctrl and tsp_dp
//
// Usage: req carries one item per valid/ready handshake. A start item (cmd 1)
// loads a move: accelerate, constant or decelerate; a tick item (cmd 0) carries
// the motor step position and advances the speed by one step. Every item gives
// exactly one result on rsp: the velocity command, its write strobe, the
// position clear strobe, the done flag and the phase after the item.
// Configuration (floor speed, accel, mm per step, velocity scale) is written
// on cfg_wr_en with cfg_index / cfg_data; the user must do so only while no
// item is in flight, which the block itself does not enforce.
// The shared two-bit-per-cycle divider serves valid start items and ticks in
// decel hold. The block takes one item at a time: a new item is accepted only
// once the result of the last one has moved into the output register.
// Reset clears the move to idle and loads the default configuration.
// A stalled rsp holds its result; one new item can be taken and worked on
// meanwhile, and its result waits until the held one is taken.
module trapezoid_speed_profile_unit
	import tsp_pkg::*;
#(
	parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tsp_req_if.sink               req,
	tsp_rsp_if.source             rsp
);
	item_t      item;
	res_t       res;
	dp_cmd_t    ctl;
	dp_status_t stat;

	assign item.cmd          = req.cmd;
	assign item.move_kind    = req.move_kind;
	assign item.move_length  = req.move_length;
	assign item.target_speed = req.target_speed;
	assign item.step_count   = req.step_count;

	assign rsp.velocity_write = res.velocity_write;
	assign rsp.velocity_cmd   = res.velocity_cmd;
	assign rsp.clear_count    = res.clear_count;
	assign rsp.done_res       = res.done_res;
	assign rsp.phase          = res.phase;

	tsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tsp_dp #(
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.ctl       (ctl),
		.stat      (stat),
		.res       (res)
	);

endmodule

>>> sv/tsp_div.sv
// tsp_div: iterative restoring divider, unsigned, two quotient bits per cycle
// standalone; shared by the goal step count and the braking distance in tsp_dp
module tsp_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	localparam int STEPS = 2;
	localparam int ITER  = (NUM_W + STEPS - 1) / STEPS;
	localparam int NUM_P = ITER * STEPS;
	localparam int CNT_W = $clog2(ITER + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_P-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   step_rem;
	logic [DEN_W:0]   step_trial;
	logic [NUM_P-1:0] step_quo;

	// numerator bits leave the top of quo_q while quotient bits enter at the bottom
	always_comb begin
		step_rem   = rem_q;
		step_quo   = quo_q;
		step_trial = '0;
		for (int i = 0; i < STEPS; i++) begin
			step_trial = {step_rem[DEN_W-1:0], step_quo[NUM_P-1]};
			step_quo   = {step_quo[NUM_P-2:0], 1'b0};
			if (step_trial >= {1'b0, den_q}) begin
				step_rem    = step_trial - {1'b0, den_q};
				step_quo[0] = 1'b1;
			end else begin
				step_rem = step_trial;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= NUM_P'(num);
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= step_rem;
			quo_q <= step_quo;
		end
	end

	assign quo  = quo_q[NUM_W-1:0];
	assign done = done_q;

endmodule

>>> sv/tsp_ctrl.sv
// tsp_ctrl: sequencer of the speed profile unit, owns both channel handshakes
// depends on tsp_pkg; drives tsp_dp through dp_cmd_t and reads dp_status_t
module tsp_ctrl
	import tsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t stat,
	output dp_cmd_t    ctl
);
	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	// the output register may be refilled in the cycle it is taken
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.cmd == CMD_START) begin
					state_d = stat.kind_ok ? ST_GOAL_DIV : ST_RESULT;
				end else begin
					state_d = (stat.phase == PH_IDLE) ? ST_RESULT : ST_STEP;
				end
			end
			ST_GOAL_DIV:  state_d = ST_GOAL_WAIT;
			ST_GOAL_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_VEL_MUL;
				end
			end
			ST_STEP:      state_d = ST_VEL_MUL;
			ST_VEL_MUL:   state_d = ST_VEL_SAT;
			ST_VEL_SAT: begin
				if (stat.cmd == CMD_START) begin
					state_d = ST_RESULT;
				end else if (stat.phase == PH_HOLD) begin
					state_d = ST_TRAV_MUL;
				end else begin
					state_d = ST_GOAL_CMP;
				end
			end
			ST_GOAL_CMP:  state_d = ST_RESULT;
			ST_TRAV_MUL:  state_d = ST_REM;
			ST_REM:       state_d = ST_SQ_MUL;
			ST_SQ_MUL:    state_d = ST_FL_MUL;
			ST_FL_MUL:    state_d = ST_NUM;
			ST_NUM:       state_d = ST_BRAKE_DIV;
			ST_BRAKE_DIV: state_d = ST_BRAKE_WAIT;
			ST_BRAKE_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_BRAKE_CMP;
				end
			end
			ST_BRAKE_CMP: state_d = ST_RESULT;
			ST_RESULT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		ctl.capture = (state_q == ST_IDLE) && in_valid;
		ctl.op      = OP_NONE;
		case (state_q)
			ST_GOAL_DIV:   ctl.op = OP_DIV_GOAL;
			ST_GOAL_WAIT:  ctl.op = stat.div_done ? OP_START_SET : OP_NONE;
			ST_STEP:       ctl.op = OP_STEP;
			ST_VEL_MUL:    ctl.op = OP_MUL_VEL;
			ST_VEL_SAT:    ctl.op = OP_VEL_SAT;
			ST_GOAL_CMP:   ctl.op = OP_GOAL_CMP;
			ST_TRAV_MUL:   ctl.op = OP_MUL_TRAV;
			ST_REM:        ctl.op = OP_REM;
			ST_SQ_MUL:     ctl.op = OP_MUL_SQ;
			ST_FL_MUL:     ctl.op = OP_MUL_FL;
			ST_NUM:        ctl.op = OP_NUM;
			ST_BRAKE_DIV:  ctl.op = OP_DIV_BRAKE;
			ST_BRAKE_CMP:  ctl.op = OP_BRAKE_CMP;
			ST_RESULT:     ctl.op = slot_free ? OP_EMIT : OP_NONE;
			default:       ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/tsp_dp.sv
// tsp_dp: datapath of the speed profile unit: config registers, move state,
// one shared 32x32 multiplier, the divider and the result register
// depends on tsp_pkg and tsp_div; sequenced by tsp_ctrl
module tsp_dp
	import tsp_pkg::*;
#(
	parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  item_t                 item,
	input  dp_cmd_t               ctl,
	output dp_status_t            stat,
	output res_t                  res
);
	localparam int F          = SPEED_FRAC_BITS;
	localparam int SPW        = TGT_W + F;
	localparam int AW         = ACC_CFG_W + F - ACC_CFG_FRAC;
	localparam int SQW        = 2 * SPW;
	localparam int GOAL_NUM_W = LEN_W + MPS_FRAC;
	localparam int DIV_N_W    = (SQW > GOAL_NUM_W) ? SQW : GOAL_NUM_W;
	localparam int DEN_W      = AW + BRAKE_K_W + F;
	localparam int DIV_D_W    = (DEN_W > MPS_W) ? DEN_W : MPS_W;
	localparam int TRAV_W     = MUL_W + MPS_W - MPS_FRAC;
	localparam int REM_W      = TRAV_W + 2;
	localparam int BD_W       = DIV_N_W + 1;
	localparam int CMP_W      = ((REM_W > BD_W) ? REM_W : BD_W) + 1;

	// configuration
	logic [FLOOR_W-1:0]   floor_q;
	logic [ACC_CFG_W-1:0] acc_cfg_q;
	logic [MPS_W-1:0]     mps_q;
	logic [VSC_W-1:0]     vsc_q;

	// captured item
	logic [CMD_W-1:0]         cmd_q;
	logic [KIND_W-1:0]        kind_q;
	logic [LEN_W-1:0]         len_in_q;
	logic [TGT_W-1:0]         tgt_q;
	logic signed [STEP_W-1:0] sc_q;

	// move state
	logic [SPW-1:0]           speed_q;
	logic [SPW-1:0]           low_q;
	logic [SPW-1:0]           high_q;
	logic signed [AW:0]       accel_q;
	logic signed [STEP_W-1:0] goal_steps_q;
	logic [LEN_W-1:0]         goal_len_q;
	phase_t                   phase_q;

	// working registers
	logic                     wr_q;
	logic                     clr_q;
	logic                     fin_q;
	logic [VEL_W-1:0]         vel_q;
	logic [2*MUL_W-1:0]       prod_q;
	logic signed [REM_W-1:0]  rem_q;
	logic [SQW-1:0]           sq_q;
	logic signed [SQW:0]      num_q;
	logic [DEN_W-1:0]         den_q;
	res_t                     res_q;

	logic [AW-1:0]            acc_raw;
	logic [SPW-1:0]           fq;
	logic [SPW-1:0]           tq;
	logic                     kind_ok;
	logic                     mul_en;
	logic [MUL_W-1:0]         mul_a;
	logic [MUL_W-1:0]         mul_b;
	logic [MUL_W-1:0]         sc_mag;
	logic signed [SPW+1:0]    step_sum;
	logic signed [SPW+1:0]    step_lim;
	logic [2*MUL_W-1:0]       vel_full;
	logic [VEL_W-1:0]         vel_sat;
	logic [TRAV_W-1:0]        trav_mag;
	logic signed [REM_W-1:0]  trav_pos;
	logic signed [REM_W-1:0]  trav_s;
	logic [AW+BRAKE_K_W-1:0]  acc_k;
	logic signed [SQW:0]      num_neg;
	logic [SQW-1:0]           num_mag;
	logic                     div_start;
	logic [DIV_N_W-1:0]       div_num;
	logic [DIV_D_W-1:0]       div_den;
	logic [DIV_N_W-1:0]       div_quo;
	logic                     div_done;
	logic [STEP_W-1:0]        goal_sat;
	logic signed [CMP_W-1:0]  quo_ext;
	logic signed [CMP_W-1:0]  bd;
	logic signed [CMP_W-1:0]  rem_ext;

	assign acc_raw = AW'({acc_cfg_q, {F{1'b0}}} >> ACC_CFG_FRAC);
	assign fq      = {floor_q, {F{1'b0}}};
	assign tq      = {tgt_q, {F{1'b0}}};
	assign kind_ok = (kind_q == KIND_ACCEL) || (kind_q == KIND_CONST) ||
		(kind_q == KIND_DECEL);

	// shared multiplier operand select
	assign sc_mag = sc_q[STEP_W-1] ? MUL_W'(-sc_q) : MUL_W'(sc_q);

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (ctl.op)
			OP_MUL_VEL: begin
				mul_a = MUL_W'(speed_q);
				mul_b = vsc_q;
			end
			OP_MUL_TRAV: begin
				mul_a = sc_mag;
				mul_b = mps_q;
			end
			OP_MUL_SQ: begin
				mul_a = MUL_W'(speed_q);
				mul_b = MUL_W'(speed_q);
			end
			OP_MUL_FL: begin
				mul_a = MUL_W'(fq);
				mul_b = MUL_W'(fq);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// speed step: add accel, clamp high first, then low
	always_comb begin
		step_sum = $signed({2'b00, speed_q}) +
			$signed({{(SPW+1-AW){accel_q[AW]}}, accel_q});
		step_lim = step_sum;
		if (step_lim > $signed({2'b00, high_q})) begin
			step_lim = $signed({2'b00, high_q});
		end
		if (step_lim < $signed({2'b00, low_q})) begin
			step_lim = $signed({2'b00, low_q});
		end
	end

	assign vel_full = prod_q >> (F + VSC_FRAC);
	assign vel_sat  = (vel_full > (2*MUL_W)'(VEL_SAT)) ? VEL_SAT : vel_full[VEL_W-1:0];

	assign trav_mag = prod_q[2*MUL_W-1:MPS_FRAC];
	assign trav_pos = $signed({2'b00, trav_mag});
	assign trav_s   = sc_q[STEP_W-1] ? -trav_pos : trav_pos;

	assign acc_k   = (AW+BRAKE_K_W)'(accel_q[AW-1:0]) * (AW+BRAKE_K_W)'(BRAKE_K);
	assign num_neg = -num_q;
	assign num_mag = num_q[SQW] ? num_neg[SQW-1:0] : num_q[SQW-1:0];

	assign div_start = (ctl.op == OP_DIV_GOAL) || (ctl.op == OP_DIV_BRAKE);
	assign div_num   = (ctl.op == OP_DIV_GOAL) ?
		DIV_N_W'({len_in_q, {MPS_FRAC{1'b0}}}) : DIV_N_W'(num_mag);
	assign div_den   = (ctl.op == OP_DIV_GOAL) ? DIV_D_W'(mps_q) : DIV_D_W'(den_q);

	tsp_div #(
		.NUM_W (DIV_N_W),
		.DEN_W (DIV_D_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// a zero step size divides to all ones and saturates here as well
	assign goal_sat = (div_quo > DIV_N_W'(GOAL_SAT)) ? GOAL_SAT : div_quo[STEP_W-1:0];

	// braking distance truncates toward zero; zero when accel is not positive
	assign quo_ext = $signed({{(CMP_W-DIV_N_W){1'b0}}, div_quo});
	always_comb begin
		if (accel_q[AW] || (accel_q == '0)) begin
			bd = '0;
		end else if (num_q[SQW]) begin
			bd = -quo_ext;
		end else begin
			bd = quo_ext;
		end
	end
	assign rem_ext = $signed({{(CMP_W-REM_W){rem_q[REM_W-1]}}, rem_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= FLOOR_W'(30);
			acc_cfg_q <= ACC_CFG_W'(384);
			mps_q     <= MPS_W'(157286);
			vsc_q     <= VSC_W'(65536);
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FLOOR_SPEED: floor_q   <= cfg_data[FLOOR_W-1:0];
				CFG_ACCEL:       acc_cfg_q <= cfg_data[ACC_CFG_W-1:0];
				CFG_MM_PER_STEP: mps_q     <= cfg_data[MPS_W-1:0];
				CFG_VEL_SCALE:   vsc_q     <= cfg_data[VSC_W-1:0];
				default:         floor_q   <= floor_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q      <= '0;
			low_q        <= '0;
			high_q       <= '0;
			accel_q      <= '0;
			goal_steps_q <= '0;
			goal_len_q   <= '0;
			phase_q      <= PH_IDLE;
		end else begin
			case (ctl.op)
				OP_START_SET: begin
					goal_steps_q <= $signed(goal_sat);
					goal_len_q   <= len_in_q;
					if (kind_q == KIND_ACCEL) begin
						accel_q <= $signed({1'b0, acc_raw});
						speed_q <= fq;
						low_q   <= fq;
						high_q  <= tq;
						phase_q <= PH_RAMP;
					end else begin
						accel_q <= (kind_q == KIND_DECEL) ? $signed({1'b0, acc_raw}) : '0;
						speed_q <= tq;
						low_q   <= tq;
						high_q  <= tq;
						phase_q <= (kind_q == KIND_DECEL) ? PH_HOLD : PH_CRUISE;
					end
				end
				OP_STEP: speed_q <= step_lim[SPW-1:0];
				OP_GOAL_CMP: begin
					if (sc_q > goal_steps_q) begin
						phase_q <= PH_IDLE;
					end
				end
				OP_BRAKE_CMP: begin
					if (rem_ext < bd) begin
						accel_q <= -$signed({1'b0, acc_raw});
						low_q   <= fq;
						phase_q <= PH_BRAKE;
					end
				end
				default: phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= item.cmd;
			kind_q   <= item.move_kind;
			len_in_q <= item.move_length;
			tgt_q    <= item.target_speed;
			sc_q     <= $signed(item.step_count);
			wr_q     <= 1'b0;
			clr_q    <= 1'b0;
			fin_q    <= 1'b0;
			vel_q    <= '0;
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (ctl.op)
			OP_START_SET: begin
				wr_q  <= 1'b1;
				clr_q <= 1'b1;
			end
			OP_STEP:     wr_q  <= 1'b1;
			OP_VEL_SAT:  vel_q <= vel_sat;
			OP_GOAL_CMP: begin
				if (sc_q > goal_steps_q) begin
					fin_q <= 1'b1;
					if (phase_q == PH_BRAKE) begin
						vel_q <= '0;
					end
				end
			end
			OP_REM:      rem_q <= $signed({{(REM_W-LEN_W){1'b0}}, goal_len_q}) - trav_s;
			OP_MUL_FL:   sq_q  <= prod_q[SQW-1:0];
			OP_NUM: begin
				num_q <= $signed({1'b0, sq_q}) - $signed({1'b0, prod_q[SQW-1:0]});
				den_q <= {acc_k, {F{1'b0}}};
			end
			OP_EMIT: begin
				res_q.velocity_write <= wr_q;
				res_q.velocity_cmd   <= vel_q;
				res_q.clear_count    <= clr_q;
				res_q.done_res       <= fin_q;
				res_q.phase          <= phase_q;
			end
			default: ;
		endcase
	end

	assign stat.cmd      = cmd_q;
	assign stat.kind_ok  = kind_ok;
	assign stat.phase    = phase_q;
	assign stat.div_done = div_done;
	assign res           = res_q;

endmodule
